// ===== sv/tsb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tsb_pkg;

  // Built depth of the sample store.
  localparam int BUFFER_DEPTH = 1024;

  localparam int AW          = $clog2(BUFFER_DEPTH);
  localparam int CNT_W       = $clog2(BUFFER_DEPTH + 1);
  localparam int CFG_DEPTH_W = 11;
  localparam int CFG_W       = 11;
  localparam int EFF_W       = (CNT_W > CFG_DEPTH_W) ? CNT_W : CFG_DEPTH_W;
  localparam int SUM_W       = EFF_W + 1;
  localparam int POS_W       = 10;
  localparam int TS_W        = 64;

  localparam int IN_DATA_W   = ((TS_W + POS_W + 7) / 8) * 8;
  localparam int OUT_BITS    = TS_W + 4;
  localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CFG_DEPTH_W-1:0] DEPTH_RESET = CFG_DEPTH_W'(1024);

  typedef enum logic [0:0] {
    CFG_DEPTH_IN_USE  = 1'b0,
    CFG_CIRCULAR_MODE = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    KIND_RECORD = 1'b0,
    KIND_READ   = 1'b1
  } kind_e;

  typedef struct packed {
    logic            we;
    logic [AW-1:0]   waddr;
    logic [TS_W-1:0] wdata;
    logic            re;
    logic [AW-1:0]   raddr;
  } mem_req_t;

  typedef struct packed {
    logic use_mem;
    logic absent;
    logic dropped;
    logic full;
    logic wrapped;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/tsb_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsb_store (
  input  wire logic                     clk_i,
  input  wire tsb_pkg::mem_req_t        req_i,
  output logic [tsb_pkg::TS_W-1:0]      rd_data_o
);

  logic [tsb_pkg::TS_W-1:0] mem [tsb_pkg::BUFFER_DEPTH];
  logic [tsb_pkg::TS_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== sv/tsb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tsb_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [tsb_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                          accept_i,
  input  wire logic                          kind_i,
  input  wire logic [tsb_pkg::TS_W-1:0]      timestamp_i,
  input  wire logic [tsb_pkg::POS_W-1:0]     read_position_i,
  output tsb_pkg::mem_req_t                  mem_req_o,
  output tsb_pkg::result_t                   result_o
);

  logic [tsb_pkg::CFG_DEPTH_W-1:0] depth_cfg_q;
  logic                            circ_q;
  logic [tsb_pkg::CNT_W-1:0]       wp_q, wp_d;
  logic [tsb_pkg::CNT_W-1:0]       fill_q, fill_d;
  logic                            full_q, full_d;
  logic                            wrapped_q, wrapped_d;

  logic [tsb_pkg::EFF_W-1:0] cfg_ext;
  logic [tsb_pkg::EFF_W-1:0] depth;
  logic [tsb_pkg::CNT_W-1:0] wp_eff;
  logic [tsb_pkg::CNT_W-1:0] wp_inc;
  logic [tsb_pkg::SUM_W-1:0] pos_ext, depth_s, sum, addr_s;
  logic                      is_read, is_record, absent, hit, do_write;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_cfg_q <= tsb_pkg::DEPTH_RESET;
      circ_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tsb_pkg::CFG_DEPTH_IN_USE:  depth_cfg_q <= cfg_wdata_i[tsb_pkg::CFG_DEPTH_W-1:0];
        tsb_pkg::CFG_CIRCULAR_MODE: circ_q      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Depth in use, clamped to 1 .. BUFFER_DEPTH.
  always_comb begin
    cfg_ext = tsb_pkg::EFF_W'(depth_cfg_q);
    if (cfg_ext == '0) begin
      depth = tsb_pkg::EFF_W'(1);
    end else if (cfg_ext > tsb_pkg::EFF_W'(tsb_pkg::BUFFER_DEPTH)) begin
      depth = tsb_pkg::EFF_W'(tsb_pkg::BUFFER_DEPTH);
    end else begin
      depth = cfg_ext;
    end
  end

  assign is_read   = accept_i && (kind_i == tsb_pkg::KIND_READ);
  assign is_record = accept_i && (kind_i == tsb_pkg::KIND_RECORD);
  assign do_write  = is_record && !full_q;

  assign wp_eff = (wp_q >= tsb_pkg::CNT_W'(tsb_pkg::BUFFER_DEPTH)) ? '0 : wp_q;
  assign wp_inc = wp_eff + tsb_pkg::CNT_W'(1);

  // Chronological position to store address; once wrapped the oldest
  // entry sits at the write pointer.
  always_comb begin
    pos_ext = tsb_pkg::SUM_W'(read_position_i);
    depth_s = tsb_pkg::SUM_W'(depth);
    sum     = tsb_pkg::SUM_W'(wp_q) + pos_ext;
    if (wrapped_q) begin
      addr_s = (sum >= depth_s) ? (sum - depth_s) : sum;
    end else begin
      addr_s = pos_ext;
    end
    absent = (pos_ext >= depth_s);
    // Entries at or above the fill count were never written and read as zero.
    hit    = !absent && (addr_s < tsb_pkg::SUM_W'(fill_q));
  end

  always_comb begin
    wp_d      = wp_q;
    fill_d    = fill_q;
    full_d    = full_q;
    wrapped_d = wrapped_q;
    if (do_write) begin
      wp_d = wp_inc;
      if (wp_eff == fill_q) begin
        fill_d = fill_q + tsb_pkg::CNT_W'(1);
      end
      if (tsb_pkg::EFF_W'(wp_inc) >= depth) begin
        if (circ_q) begin
          wp_d      = '0;
          wrapped_d = 1'b1;
        end else begin
          full_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      fill_q    <= '0;
      full_q    <= 1'b0;
      wrapped_q <= 1'b0;
    end else begin
      wp_q      <= wp_d;
      fill_q    <= fill_d;
      full_q    <= full_d;
      wrapped_q <= wrapped_d;
    end
  end

  always_comb begin
    mem_req_o.we    = do_write;
    mem_req_o.waddr = wp_eff[tsb_pkg::AW-1:0];
    mem_req_o.wdata = timestamp_i;
    mem_req_o.re    = is_read && hit;
    mem_req_o.raddr = addr_s[tsb_pkg::AW-1:0];

    result_o.use_mem = (kind_i == tsb_pkg::KIND_READ) && hit;
    result_o.absent  = (kind_i == tsb_pkg::KIND_READ) && absent;
    result_o.dropped = (kind_i == tsb_pkg::KIND_RECORD) && full_q;
    result_o.full    = full_d;
    result_o.wrapped = wrapped_d;
  end

  a_wp_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= fill_q)
    else $error("write pointer ahead of fill count");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= tsb_pkg::CNT_W'(tsb_pkg::BUFFER_DEPTH))
    else $error("fill count beyond built depth");

  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("full flag cleared without reset");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_record && full_q) |-> !mem_req_o.we)
    else $error("store written while linear buffer full");

endmodule

`default_nettype wire

// ===== sv/timestamp_trace_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Timestamp trace buffer. Each input beat is either a record (tuser 0),
// which stores its timestamp at the write pointer, or a read (tuser 1),
// which returns the entry at a chronological position, 0 being the oldest.
// Every beat gives exactly one result beat in the cycle after it is taken,
// and a new beat is taken every cycle as long as the result side keeps up:
// all pointer and flag updates finish in the accepting cycle, and the
// single store is written or read at most once per beat through its registered
// read port. Linear mode stops and drops records once full; circular mode
// wraps and keeps the newest entries. A fill count marks how much of the
// store has been written, so unwritten entries read as zero without any
// clearing pass after reset. Configuration writes are taken at any time
// through the cfg port and must be made while no beat is in flight.
module timestamp_trace_buffer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration write port.
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_idx_i,
  input  wire logic [tsb_pkg::CFG_W-1:0]        cfg_wdata_i,
  // Input stream.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: timestamp [63:0], read_position [73:64], zero padding above.
  input  wire logic [tsb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: kind.
  input  wire logic                             s_axis_tuser,
  // Result stream.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tdata: entry_value [63:0], entry_absent [64], record_dropped [65],
  // buffer_full [66], buffer_wrapped [67], zero padding above.
  output logic [tsb_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

  tsb_pkg::mem_req_t         mem_req;
  tsb_pkg::result_t          result;
  tsb_pkg::result_t          res_q;
  logic [tsb_pkg::TS_W-1:0]  rd_data;
  logic [tsb_pkg::TS_W-1:0]  entry_value;
  logic                      out_valid_q;
  logic                      accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  tsb_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .kind_i         (s_axis_tuser),
    .timestamp_i    (s_axis_tdata[tsb_pkg::TS_W-1:0]),
    .read_position_i(s_axis_tdata[tsb_pkg::TS_W +: tsb_pkg::POS_W]),
    .mem_req_o      (mem_req),
    .result_o       (result)
  );

  tsb_store u_store (
    .clk_i    (clk_i),
    .req_i    (mem_req),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // The read data register of the store only loads on a read that hits,
  // so it holds steady while the result beat waits.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= result;
    end
  end

  assign entry_value   = res_q.use_mem ? rd_data : '0;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tsb_pkg::OUT_DATA_W'({res_q.wrapped, res_q.full, res_q.dropped,
                                                res_q.absent, entry_value});

endmodule

`default_nettype wire

// ===== tb/sv/tb_timestamp_trace_buffer.sv =====
`timescale 1ns / 1ps

module tb_timestamp_trace_buffer;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    tsb_pkg::kind_e           kind;
    logic [tsb_pkg::TS_W-1:0]  ts;
    logic [tsb_pkg::POS_W-1:0] pos;
  } trace_op_t;

  typedef struct {
    logic [tsb_pkg::TS_W-1:0] value;
    logic                     absent;
    logic                     dropped;
    logic                     full;
    logic                     wrapped;
  } readout_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic                           cfg_idx_i = 1'b0;
  logic [tsb_pkg::CFG_W-1:0]      cfg_wdata_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [tsb_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [tsb_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  // Shadow copy of the buffer state and configuration.
  logic [tsb_pkg::TS_W-1:0]        shadow_store [tsb_pkg::BUFFER_DEPTH];
  int unsigned                     shadow_wp = 0;
  bit                              shadow_full = 1'b0;
  bit                              shadow_wrapped = 1'b0;
  logic [tsb_pkg::CFG_DEPTH_W-1:0] shadow_depth = tsb_pkg::DEPTH_RESET;
  bit                              shadow_circ = 1'b0;

  trace_op_t pending_ops[$];
  readout_t  expected_readouts[$];
  trace_op_t cur_op;
  bit        beat_busy = 1'b0;
  bit        send_calm = 1'b0;
  bit        recv_calm = 1'b0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        hold_left = 0;
  int        beats_sent = 0;
  int        results_checked = 0;
  int        dropped_seen = 0;
  int        absent_seen = 0;
  int        wrapped_seen = 0;
  int        settings_used = 0;
  int        mismatches = 0;
  int        cycle_count = 0;

  timestamp_trace_buffer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time,
               expected_readouts.size());
      $display("tb_timestamp_trace_buffer failed");
      $finish;
    end
  end

  function automatic int unsigned eff_depth();
    int unsigned d;
    d = 32'(shadow_depth);
    if (d == 0) d = 1;
    if (d > tsb_pkg::BUFFER_DEPTH) d = tsb_pkg::BUFFER_DEPTH;
    return d;
  endfunction

  // Applies one beat to the shadow state and returns the result it must produce.
  function automatic readout_t predict_readout(trace_op_t op);
    readout_t    r;
    int unsigned depth;
    int unsigned ptr;
    int unsigned addr;
    r.value   = '0;
    r.absent  = 1'b0;
    r.dropped = 1'b0;
    depth = eff_depth();
    if (op.kind == tsb_pkg::KIND_RECORD) begin
      if (shadow_full) begin
        r.dropped = 1'b1;
      end else begin
        ptr = shadow_wp;
        if (ptr >= tsb_pkg::BUFFER_DEPTH) ptr = 0;
        shadow_store[ptr] = op.ts;
        ptr++;
        // A pointer left above a lowered depth also lands here on its next record.
        if (ptr >= depth) begin
          if (shadow_circ) begin
            ptr = 0;
            shadow_wrapped = 1'b1;
          end else begin
            shadow_full = 1'b1;
          end
        end
        shadow_wp = ptr;
      end
    end else if (32'(op.pos) >= depth) begin
      r.absent = 1'b1;
    end else begin
      addr = 32'(op.pos);
      if (shadow_wrapped) begin
        addr = shadow_wp + 32'(op.pos);
        if (addr >= depth) addr -= depth;
      end
      if (addr < tsb_pkg::BUFFER_DEPTH) r.value = shadow_store[addr];
    end
    r.full    = shadow_full;
    r.wrapped = shadow_wrapped;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [tsb_pkg::TS_W-1:0] random_ts();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [tsb_pkg::POS_W-1:0] random_pos(input int unsigned hi);
    return tsb_pkg::POS_W'($urandom_range(0, hi));
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Sender: offers queued beats, with random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      beat_busy = 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_readouts.push_back(predict_readout(cur_op));
        beat_busy = 1'b0;
        beats_sent++;
        if (beats_sent % 64 == 0) send_calm = ($urandom_range(0, 2) == 0);
        gap_left = send_calm ? 0 : pick_gap();
      end
      if (!beat_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          cur_op = pending_ops.pop_front();
          beat_busy = 1'b1;
          s_axis_tdata <= tsb_pkg::IN_DATA_W'({cur_op.pos, cur_op.ts});
          s_axis_tuser <= cur_op.kind;
        end
      end
      s_axis_tvalid <= beat_busy;
    end
  end

  // Receiver: checks result beats in order and throttles tready.
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    readout_t want;
    bit       rdy;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_checked++;
        if (expected_readouts.size() == 0) begin
          $display("%0t ns: result beat %h expected none, got one", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_readouts.pop_front();
          check_field("entry_value", want.value, m_axis_tdata[63:0]);
          check_field("entry_absent", 64'(want.absent), 64'(m_axis_tdata[64]));
          check_field("record_dropped", 64'(want.dropped), 64'(m_axis_tdata[65]));
          check_field("buffer_full", 64'(want.full), 64'(m_axis_tdata[66]));
          check_field("buffer_wrapped", 64'(want.wrapped), 64'(m_axis_tdata[67]));
        end
        if (m_axis_tdata[64]) absent_seen++;
        if (m_axis_tdata[65]) dropped_seen++;
        if (m_axis_tdata[67]) wrapped_seen++;
        if (results_checked % 64 == 0) recv_calm = ($urandom_range(0, 2) == 0);
        // Long hold-off so the block backs up and drops its own tready.
        if (results_checked == 200 || results_checked == 1400) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (!recv_calm && $urandom_range(0, 99) < 25) stall_left = pick_stall();
      end
      m_axis_tready <= rdy;
    end
  end

  task automatic queue_op(input tsb_pkg::kind_e kind, input logic [tsb_pkg::TS_W-1:0] ts,
                          input logic [tsb_pkg::POS_W-1:0] pos);
    trace_op_t op;
    op.kind = kind;
    op.ts   = ts;
    op.pos  = pos;
    pending_ops.push_back(op);
  endtask

  task automatic queue_random(input int n, input int rec_pct);
    int unsigned d;
    d = eff_depth();
    repeat (n) begin
      if ($urandom_range(0, 99) < rec_pct)
        queue_op(tsb_pkg::KIND_RECORD, random_ts(), random_pos(1023));
      else if ($urandom_range(0, 9) < 7)
        queue_op(tsb_pkg::KIND_READ, random_ts(), random_pos(d - 1));
      else
        queue_op(tsb_pkg::KIND_READ, random_ts(), random_pos(1023));
    end
  endtask

  // Called right after a rising edge; the block takes the write at the next one.
  task automatic write_reg(input tsb_pkg::cfg_idx_e idx,
                           input logic [tsb_pkg::CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == tsb_pkg::CFG_DEPTH_IN_USE) shadow_depth = val;
    else shadow_circ = val[0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  task automatic wait_idle();
    while (pending_ops.size() != 0 || beat_busy || expected_readouts.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int          need;
    int          small_depths [8];
    for (int i = 0; i < tsb_pkg::BUFFER_DEPTH; i++) shadow_store[i] = '0;
    small_depths = '{16, 2, 1023, 3, 1, 9, 100, 5};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: unwritten entries read as zero, extreme timestamps.
    queue_op(tsb_pkg::KIND_READ, random_ts(), 10'd0);
    queue_op(tsb_pkg::KIND_READ, random_ts(), 10'd1023);
    queue_op(tsb_pkg::KIND_RECORD, '1, 10'd1023);
    queue_op(tsb_pkg::KIND_RECORD, '0, 10'd0);
    queue_op(tsb_pkg::KIND_RECORD, 64'h8000_0000_0000_0001, 10'h155);
    queue_op(tsb_pkg::KIND_RECORD, 64'h5555_AAAA_5555_AAAA, 10'h2AA);
    for (int p = 0; p < 4; p++) queue_op(tsb_pkg::KIND_READ, random_ts(), tsb_pkg::POS_W'(p));
    wait_idle();

    // Depth zero acts as one; the pointer sits above it, so the next record wraps.
    write_reg(tsb_pkg::CFG_DEPTH_IN_USE, 11'd0);
    write_reg(tsb_pkg::CFG_CIRCULAR_MODE, 11'd1);
    queue_op(tsb_pkg::KIND_READ, random_ts(), 10'd0);
    queue_op(tsb_pkg::KIND_RECORD, 64'h0123_4567_89AB_CDEF, 10'd0);
    queue_op(tsb_pkg::KIND_READ, random_ts(), 10'd0);
    queue_op(tsb_pkg::KIND_RECORD, 64'hFEDC_BA98_7654_3210, 10'd0);
    queue_op(tsb_pkg::KIND_READ, random_ts(), 10'd0);
    queue_op(tsb_pkg::KIND_READ, random_ts(), 10'd1);
    queue_op(tsb_pkg::KIND_READ, random_ts(), 10'd1023);
    wait_idle();

    // Depth above the built size is clamped to it.
    write_reg(tsb_pkg::CFG_DEPTH_IN_USE, 11'd2047);
    queue_op(tsb_pkg::KIND_READ, random_ts(), 10'd1023);
    queue_op(tsb_pkg::KIND_RECORD, 64'hDEAD_BEEF_0000_FFFF, 10'd0);
    queue_op(tsb_pkg::KIND_READ, random_ts(), 10'd1023);
    queue_op(tsb_pkg::KIND_READ, random_ts(), 10'd0);
    wait_idle();

    // Full-size circular run: wrap at the top and run some way past it.
    write_reg(tsb_pkg::CFG_DEPTH_IN_USE, 11'd1024);
    need = tsb_pkg::BUFFER_DEPTH - int'(shadow_wp) + 40;
    while (need > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_op(tsb_pkg::KIND_READ, random_ts(), random_pos(1023));
      end else begin
        queue_op(tsb_pkg::KIND_RECORD, random_ts(), random_pos(1023));
        need--;
      end
    end
    wait_idle();

    // Smaller circular depths; the first one lands below the current pointer.
    foreach (small_depths[i]) begin
      write_reg(tsb_pkg::CFG_DEPTH_IN_USE, tsb_pkg::CFG_W'(small_depths[i]));
      queue_random(50, 60);
      wait_idle();
    end

    // Linear mode fills up and then drops; full stays set after going circular.
    write_reg(tsb_pkg::CFG_DEPTH_IN_USE, 11'd12);
    write_reg(tsb_pkg::CFG_CIRCULAR_MODE, 11'd0);
    queue_random(70, 70);
    wait_idle();
    write_reg(tsb_pkg::CFG_DEPTH_IN_USE, 11'd6);
    write_reg(tsb_pkg::CFG_CIRCULAR_MODE, 11'd1);
    queue_random(40, 60);
    wait_idle();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d beats and checked %0d results across %0d register writes.",
             beats_sent, results_checked, settings_used);
    $display("Seen: %0d dropped records, %0d absent reads, %0d results with wrap set.",
             dropped_seen, absent_seen, wrapped_seen);
    if (mismatches == 0 && expected_readouts.size() == 0) begin
      $display("tb_timestamp_trace_buffer passed");
    end else begin
      $display("tb_timestamp_trace_buffer failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tsb_pkg.sv
sv/tsb_store.sv
sv/tsb_ctrl.sv
sv/timestamp_trace_buffer.sv
tb/sv/tb_timestamp_trace_buffer.sv
